>>> src/velocity_divergence_removal_stencil_macros.svh
// Assertion macros shared by the velocity divergence removal stencil RTL.
// Every macro expects a clock named clk and an active-low reset named arst_n in scope.
// Define NO_ASSERTIONS to compile all checks away.
`ifndef VELOCITY_DIVERGENCE_REMOVAL_STENCIL_MACROS_SVH
`define VELOCITY_DIVERGENCE_REMOVAL_STENCIL_MACROS_SVH
`ifndef NO_ASSERTIONS
// The condition holds at every clock edge outside reset.
`define VDR_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);
// The trigger implies the condition in the same cycle.
`define VDR_ASSERT_IMPL(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);
// The trigger implies the condition in the next cycle.
`define VDR_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);
`else
`define VDR_ASSERT(label, cond, msg)
`define VDR_ASSERT_IMPL(label, trig, cond, msg)
`define VDR_ASSERT_NEXT(label, trig, cond, msg)
`endif
`endif

>>> src/vdr_pkg.sv
// Shared types, constants and helpers for the velocity divergence removal stencil.
// Used by every module of the block but vdr_ram; depends on nothing.
package vdr_pkg;

	// Width of one velocity component and of the exact stencil sums.
	localparam int COMP_BITS = 16;
	localparam int SUM_BITS = COMP_BITS + 5;

	// Configuration register widths and reset values.
	localparam int FW_BITS = 7;
	localparam int FH_BITS = 13;
	localparam int CFG_DATA_BITS = FH_BITS;
	localparam int ROW_BITS = 13;
	localparam int HEIGHT_LIMIT = 4096;
	localparam logic [FW_BITS-1:0] FRAME_WIDTH_RESET = 7'd64;
	localparam logic [FH_BITS-1:0] FRAME_HEIGHT_RESET = 13'd64;
	localparam int DEFAULT_MAX_WIDTH = 64;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	// One input item.
	typedef struct packed {
		logic                        action;
		logic signed [COMP_BITS-1:0] vel_x;
		logic signed [COMP_BITS-1:0] vel_y;
	} sample_t;

	// One result item.
	typedef struct packed {
		logic signed [COMP_BITS-1:0] out_x;
		logic signed [COMP_BITS-1:0] out_y;
		logic                        frame_last;
	} result_t;

	// A velocity pair as held in the window and line stores.
	typedef struct packed {
		logic signed [COMP_BITS-1:0] x;
		logic signed [COMP_BITS-1:0] y;
	} pair_t;

	// One line memory word: two rows back and one row back of a column.
	typedef struct packed {
		pair_t upper;
		pair_t middle;
	} line_t;

	// Position flags of one item, from the scan counters to the datapath.
	typedef struct packed {
		logic ignore;
		logic produce;
		logic last;
		logic left_ok;
		logic right_ok;
		logic up_ok;
		logic down_ok;
		logic narrow;
	} pos_info_t;

	// Sign-extend a component to the sum width.
	function automatic logic signed [SUM_BITS-1:0] widen(input logic signed [COMP_BITS-1:0] v);
		return {{(SUM_BITS - COMP_BITS){v[COMP_BITS-1]}}, v};
	endfunction

endpackage

>>> src/vdr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; holds the line stores of the stencil.
module vdr_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port, and a read port that returns the old word on a collision.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> src/vdr_scan.sv
// Configuration registers and raster position counters of the stencil.
// Depends on vdr_pkg and the assertion macro header.
`include "velocity_divergence_removal_stencil_macros.svh"

module vdr_scan #(
	parameter int MAX_WIDTH = vdr_pkg::DEFAULT_MAX_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  vdr_pkg::cfg_reg_t                   cfg_index,
	input  logic [vdr_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  logic                                accept,
	input  logic                                action,
	output logic [$clog2(MAX_WIDTH)-1:0]        col,
	output vdr_pkg::pos_info_t                  pos
);

	localparam int IW = $clog2(MAX_WIDTH);
	localparam int EW = IW + 1;
	localparam int YW = vdr_pkg::ROW_BITS + 2;

	logic [vdr_pkg::FW_BITS-1:0]  fw_q;
	logic [vdr_pkg::FH_BITS-1:0]  fh_q;
	logic [IW-1:0]                col_q;
	logic [vdr_pkg::ROW_BITS-1:0] row_q;

	logic [EW-1:0]                w_eff;
	logic [vdr_pkg::FH_BITS-1:0]  h_eff;
	logic [IW-1:0]                col_cur;
	logic [IW-1:0]                xc;
	logic [YW-1:0]                yc;
	logic [YW-2:0]                yc_lo;
	logic [YW-2:0]                h_ext;
	logic                         wrap;

	// Clamp the configured frame size to the supported range.
	always_comb begin
		if (fw_q == '0) begin
			w_eff = EW'(1);
		end else if (32'(fw_q) > 32'(MAX_WIDTH)) begin
			w_eff = EW'(MAX_WIDTH);
		end else begin
			w_eff = EW'(fw_q);
		end
		if (fh_q == '0) begin
			h_eff = vdr_pkg::FH_BITS'(1);
		end else if (fh_q > vdr_pkg::FH_BITS'(vdr_pkg::HEIGHT_LIMIT)) begin
			h_eff = vdr_pkg::FH_BITS'(vdr_pkg::HEIGHT_LIMIT);
		end else begin
			h_eff = fh_q;
		end
	end

	// Centre position of the window after this item enters it.
	always_comb begin
		col_cur = (EW'(col_q) >= w_eff) ? '0 : col_q;
		xc = (col_cur != '0) ? col_cur - IW'(1) : IW'(w_eff - EW'(1));
		yc = {2'b00, row_q} - YW'((col_cur != '0) ? 1 : 2);
		yc_lo = yc[YW-2:0];
		h_ext = {1'b0, h_eff};
		wrap = (EW'(col_cur) + EW'(1)) >= w_eff;

		pos.ignore   = action && (col_cur == '0) && (row_q == '0);
		pos.produce  = !yc[YW-1] && (yc_lo < h_ext);
		pos.last     = (EW'(xc) == w_eff - EW'(1)) && (yc_lo == h_ext - (YW-1)'(1));
		pos.left_ok  = xc != '0;
		pos.right_ok = (EW'(xc) + EW'(1)) < w_eff;
		pos.up_ok    = !yc[YW-1] && (yc != '0);
		pos.down_ok  = (yc_lo + (YW-1)'(1)) < h_ext;
		pos.narrow   = w_eff == EW'(1);
	end

	assign col = col_cur;

	// Registers and counters; a configuration write restarts the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q  <= vdr_pkg::FRAME_WIDTH_RESET;
			fh_q  <= vdr_pkg::FRAME_HEIGHT_RESET;
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				vdr_pkg::REG_FRAME_WIDTH: begin
					fw_q <= cfg_data[vdr_pkg::FW_BITS-1:0];
				end
				vdr_pkg::REG_FRAME_HEIGHT: begin
					fh_q <= cfg_data;
				end
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (accept && !pos.ignore) begin
			if (pos.produce && pos.last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (wrap) begin
				col_q <= '0;
				row_q <= row_q + vdr_pkg::ROW_BITS'(1);
			end else begin
				col_q <= col_cur + IW'(1);
			end
		end
	end

	`VDR_ASSERT(a_col_in_frame, EW'(col_q) < w_eff, "column counter beyond frame width")
	`VDR_ASSERT_NEXT(a_last_restarts, accept && !cfg_valid && !pos.ignore && pos.produce && pos.last, (col_q == '0) && (row_q == '0), "frame did not restart after its last pixel")
	`VDR_ASSERT_NEXT(a_ignore_holds, accept && !cfg_valid && pos.ignore, $stable(col_q) && $stable(row_q), "ignored flush moved the counters")

endmodule

>>> src/vdr_kernel.sv
// Gradient-of-divergence stencil arithmetic on a registered 3x3 window.
// Depends on vdr_pkg; purely combinational.
module vdr_kernel (
	input  vdr_pkg::pair_t [8:0]  win,
	input  vdr_pkg::pos_info_t    pos,
	output vdr_pkg::result_t      res
);

	localparam int SW = vdr_pkg::SUM_BITS;
	localparam int CW = vdr_pkg::COMP_BITS;

	logic signed [SW-1:0] mx [9];
	logic signed [SW-1:0] my [9];
	logic [2:0]           col_ok;
	logic [2:0]           row_ok;
	logic signed [SW-1:0] sx;
	logic signed [SW-1:0] sy;
	logic signed [SW-1:0] tx;
	logic signed [SW-1:0] ty;

	// Clamp an exact sum to the signed component range.
	function automatic logic [CW-1:0] sat(input logic signed [SW-1:0] v);
		if ((&v[SW-1:CW-1]) || !(|v[SW-1:CW-1])) begin
			return v[CW-1:0];
		end
		return v[SW-1] ? {1'b1, {(CW - 1){1'b0}}} : {1'b0, {(CW - 1){1'b1}}};
	endfunction

	// Neighbours outside the frame read as zero.
	always_comb begin
		col_ok = {pos.right_ok, 1'b1, pos.left_ok};
		row_ok = {pos.down_ok, 1'b1, pos.up_ok};
		for (int k = 0; k < 9; k++) begin
			if (col_ok[k % 3] && row_ok[k / 3]) begin
				mx[k] = vdr_pkg::widen(win[k].x);
				my[k] = vdr_pkg::widen(win[k].y);
			end else begin
				mx[k] = '0;
				my[k] = '0;
			end
		end
	end

	// Exact stencil sums, floor of one eighth, then the centre vector added.
	always_comb begin
		sx = mx[0] - my[0] - (mx[1] <<< 1) + mx[2] + my[2] + (mx[3] <<< 1)
			- (mx[4] <<< 2) + (mx[5] <<< 1) + mx[6] + my[6] - (mx[7] <<< 1)
			+ mx[8] - my[8];
		sy = my[0] - mx[0] + (my[1] <<< 1) + mx[2] + my[2] - (my[3] <<< 1)
			- (my[4] <<< 2) - (my[5] <<< 1) + mx[6] + my[6] + (my[7] <<< 1)
			- mx[8] + my[8];
		tx = vdr_pkg::widen(win[4].x) + (sx >>> 3);
		ty = vdr_pkg::widen(win[4].y) + (sy >>> 3);
		res.out_x      = sat(tx);
		res.out_y      = sat(ty);
		res.frame_last = pos.last;
	end

endmodule

>>> src/velocity_divergence_removal_stencil.sv
// Velocity divergence removal stencil: top level with pipeline, line memory and window.
// Depends on vdr_pkg, vdr_scan, vdr_ram, vdr_kernel and the assertion macro header.
//
// Usage:
// Velocity samples enter in raster order on the sample channel (valid/ready); a flush
// item (action set) stands for a zero sample and pushes out the tail of a frame. Each
// result on the result channel is the corrected vector of one pixel; frame_last marks
// the last pixel of the frame. The result for a pixel is caused by the item that
// arrives frame_width+1 positions later. The input register loads at the edge that
// accepts that item, the window register when that stage advances and the result
// register after that; the result is presented from the result register.
// Throughput is one item per clock while the receiver keeps up: the line memory is read
// when an item is taken and written as the item leaves the input register, with a
// bypass when the frame is one column wide.
// Configuration writes on the cfg channel are always taken and restart the frame.
// Reset clears the counters and pipeline valid bits and sets both frame sizes to 64.
// The line memory is not swept: frame-edge masking hides every entry not yet written
// in the current frame, so the block accepts items from the first cycle after reset.
// When the receiver stalls, up to three items are held in the pipeline before
// sample_ready drops; items that cause no result leave the window stage without waiting.
`include "velocity_divergence_removal_stencil_macros.svh"

module velocity_divergence_removal_stencil #(
	parameter int MAX_WIDTH = vdr_pkg::DEFAULT_MAX_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              sample_valid,
	output logic                              sample_ready,
	input  vdr_pkg::sample_t                  sample,
	output logic                              result_valid,
	input  logic                              result_ready,
	output vdr_pkg::result_t                  result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  vdr_pkg::cfg_reg_t                 cfg_index,
	input  logic [vdr_pkg::CFG_DATA_BITS-1:0] cfg_data
);

	localparam int IW = $clog2(MAX_WIDTH);

	logic                  accept;
	logic [IW-1:0]         col;
	vdr_pkg::pos_info_t    pos;

	logic                  valid_s1;
	vdr_pkg::pair_t        vel_s1;
	logic [IW-1:0]         col_s1;
	vdr_pkg::pos_info_t    pos_s1;
	logic                  valid_s2;
	vdr_pkg::pos_info_t    pos_s2;
	vdr_pkg::pair_t [8:0]  win_q;
	logic                  fwd_q;
	vdr_pkg::line_t        fwd_line_q;
	logic                  out_valid_q;
	vdr_pkg::result_t      result_q;

	vdr_pkg::pair_t        vel_in;
	vdr_pkg::line_t        ram_rd;
	vdr_pkg::line_t        rd_line;
	vdr_pkg::line_t        wr_line;
	vdr_pkg::result_t      kernel_res;
	logic                  s1_adv;
	logic                  s2_free;
	logic                  s2_adv;
	logic                  out_free;

	// Pipeline flow control, from the result register back to the input.
	assign out_free     = !out_valid_q || result_ready;
	assign s2_adv       = valid_s2 && (!pos_s2.produce || out_free);
	assign s2_free      = !valid_s2 || s2_adv;
	assign s1_adv       = valid_s1 && s2_free;
	assign sample_ready = !valid_s1 || s1_adv;
	assign accept       = sample_valid && sample_ready;
	assign cfg_ready    = 1'b1;

	vdr_scan #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.action    (sample.action),
		.col       (col),
		.pos       (pos)
	);

	// A flush item enters as a zero velocity.
	always_comb begin
		if (sample.action) begin
			vel_in = '0;
		end else begin
			vel_in.x = sample.vel_x;
			vel_in.y = sample.vel_y;
		end
	end

	// Column word of the line stores, with bypass of the word written this cycle.
	always_comb begin
		rd_line = fwd_q ? fwd_line_q : ram_rd;
		wr_line.upper  = rd_line.middle;
		wr_line.middle = vel_s1;
	end

	vdr_ram #(
		.WIDTH ($bits(vdr_pkg::line_t)),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (s1_adv),
		.waddr (col_s1),
		.wdata (wr_line),
		.re    (accept),
		.raddr (col),
		.rdata (ram_rd)
	);

	vdr_kernel u_kernel (
		.win (win_q),
		.pos (pos_s2),
		.res (kernel_res)
	);

	// Control state of the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			fwd_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= !pos.ignore;
				fwd_q    <= s1_adv && pos.narrow;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				valid_s2 <= 1'b1;
			end else if (s2_adv) begin
				valid_s2 <= 1'b0;
			end
			if (s2_adv && pos_s2.produce) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: input stage, window shift and result register.
	always_ff @(posedge clk) begin
		if (accept) begin
			vel_s1     <= vel_in;
			col_s1     <= col;
			pos_s1     <= pos;
			fwd_line_q <= wr_line;
		end
		if (s1_adv) begin
			pos_s2   <= pos_s1;
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= rd_line.upper;
			win_q[3] <= win_q[4];
			win_q[4] <= win_q[5];
			win_q[5] <= rd_line.middle;
			win_q[6] <= win_q[7];
			win_q[7] <= win_q[8];
			win_q[8] <= vel_s1;
		end
		if (s2_adv && pos_s2.produce) begin
			result_q <= kernel_res;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = result_q;

	`VDR_ASSERT_IMPL(a_byp_col, accept && s1_adv && pos.narrow, col == col_s1, "bypass column")
	`VDR_ASSERT_NEXT(a_ignore_dropped, accept && pos.ignore, !valid_s1, "ignored flush kept")
	`VDR_ASSERT_IMPL(a_ready_when_empty, !valid_s1, sample_ready, "empty stage refused item")

endmodule
